/* rtl/core/sae_pkg.sv */
// Shared types, constants and field widths for the sensor alarm edge monitor.
package sae_pkg;

    localparam int IDX_W      = 6;
    localparam int IDX_RANGE  = 2 ** IDX_W;
    localparam int IDX_EXT_W  = 13;
    localparam int KIND_W     = 2;
    localparam int VAL_W      = 24;
    localparam int AGE_W      = 32;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SAE_SENSORS = 64;

    // Alarm bit positions in every mask
    localparam int BIT_TIMEOUT  = 0;
    localparam int BIT_INVALID  = 1;
    localparam int BIT_HIGHTEMP = 2;
    localparam int BIT_HUMIDITY = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_OTHER    = 2'd0,
        KIND_TEMP     = 2'd1,
        KIND_HUMIDITY = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_HIGH = 3'd0,
        REG_HUM_LOW   = 3'd1,
        REG_HUM_HIGH  = 3'd2,
        REG_TIMEOUT   = 3'd3,
        REG_SANE_LOW  = 3'd4,
        REG_SANE_HIGH = 3'd5
    } cfg_reg_t;

    localparam logic signed [VAL_W-1:0] RST_TEMP_HIGH = 24'sd8960;
    localparam logic signed [VAL_W-1:0] RST_HUM_LOW   = 24'sd5120;
    localparam logic signed [VAL_W-1:0] RST_HUM_HIGH  = 24'sd17920;
    localparam logic [AGE_W-1:0]        RST_TIMEOUT   = 32'd300;
    localparam logic signed [VAL_W-1:0] RST_SANE_LOW  = -24'sd12800;
    localparam logic signed [VAL_W-1:0] RST_SANE_HIGH = 24'sd256000;

    typedef struct packed {
        logic signed [VAL_W-1:0] temp_high;
        logic signed [VAL_W-1:0] hum_low;
        logic signed [VAL_W-1:0] hum_high;
        logic [AGE_W-1:0]        timeout;
        logic signed [VAL_W-1:0] sane_low;
        logic signed [VAL_W-1:0] sane_high;
    } limits_t;

    typedef struct packed {
        logic [MASK_W-1:0] eval;
        logic [MASK_W-1:0] cond;
    } flag_upd_t;

endpackage

/* rtl/core/sae_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sae_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sae_cfg.sv */
// Limit registers written through the plain configuration port.
module sae_cfg
    import sae_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output limits_t               limits
);

    limits_t lim_reg;
    limits_t lim_next;

    always_comb
    begin
        lim_next = lim_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TEMP_HIGH: lim_next.temp_high = cfg_data[VAL_W-1:0];
                REG_HUM_LOW:   lim_next.hum_low   = cfg_data[VAL_W-1:0];
                REG_HUM_HIGH:  lim_next.hum_high  = cfg_data[VAL_W-1:0];
                REG_TIMEOUT:   lim_next.timeout   = cfg_data[AGE_W-1:0];
                REG_SANE_LOW:  lim_next.sane_low  = cfg_data[VAL_W-1:0];
                REG_SANE_HIGH: lim_next.sane_high = cfg_data[VAL_W-1:0];
                default:       lim_next = lim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.temp_high <= RST_TEMP_HIGH;
            lim_reg.hum_low   <= RST_HUM_LOW;
            lim_reg.hum_high  <= RST_HUM_HIGH;
            lim_reg.timeout   <= RST_TIMEOUT;
            lim_reg.sane_low  <= RST_SANE_LOW;
            lim_reg.sane_high <= RST_SANE_HIGH;
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    assign limits = lim_reg;

endmodule

/* rtl/core/sae_eval.sv */
// Alarm condition evaluation: which alarms apply and which are true for one request.
module sae_eval
    import sae_pkg::*;
(
    input  logic [KIND_W-1:0]       sensor_kind,
    input  logic                    reading_found,
    input  logic                    reading_numeric,
    input  logic signed [VAL_W-1:0] reading_value,
    input  logic [AGE_W-1:0]        reading_age,
    input  limits_t                 limits,
    output flag_upd_t               upd
);

    logic invalid;

    always_comb
    begin
        invalid = !reading_numeric || (reading_value < limits.sane_low) ||
                  (reading_value > limits.sane_high);

        upd.eval = '0;
        upd.cond = '0;

        upd.eval[BIT_TIMEOUT] = 1'b1;
        upd.cond[BIT_TIMEOUT] = !reading_found || (reading_age > limits.timeout);

        if (reading_found)
        begin
            upd.eval[BIT_INVALID] = 1'b1;
            upd.cond[BIT_INVALID] = invalid;
            priority if (sensor_kind == KIND_TEMP)
            begin
                upd.eval[BIT_HIGHTEMP] = 1'b1;
                upd.cond[BIT_HIGHTEMP] = !invalid && (reading_value > limits.temp_high);
            end
            else if (sensor_kind == KIND_HUMIDITY)
            begin
                upd.eval[BIT_HUMIDITY] = 1'b1;
                upd.cond[BIT_HUMIDITY] = !invalid && ((reading_value < limits.hum_low) ||
                                                      (reading_value > limits.hum_high));
            end
            else
            begin
                // other kinds keep their kind-specific flags
                upd.eval[BIT_HIGHTEMP] = 1'b0;
            end
        end
    end

endmodule

/* rtl/core/sensor_alarm_edge_monitor.sv */
// Top level: open-flag table read-modify-write with forwarding and output register.
// Path: stage 1 (flag-table read), then the output register; both hold while stalled.
// Throughput: one request per cycle while not stalled, set by the single flag-table
// read-modify-write; a write forward covers back-to-back requests for the same sensor.
// Reset: per-entry valid bits clear at once, so every flag reads zero; limits take defaults.
// The block accepts requests in the first cycle after reset; no clearing pass.
module sensor_alarm_edge_monitor
    import sae_pkg::*;
#(
    parameter int SENSORS = SAE_SENSORS
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [IDX_W-1:0]        sensor_index,
    input  logic [KIND_W-1:0]       sensor_kind,
    input  logic                    reading_found,
    input  logic                    reading_numeric,
    input  logic signed [VAL_W-1:0] reading_value,
    input  logic [AGE_W-1:0]        reading_age,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IDX_W-1:0]        alarm_sensor,
    output logic [MASK_W-1:0]       opened_mask,
    output logic [MASK_W-1:0]       cleared_mask,
    output logic [MASK_W-1:0]       active_mask,

    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // Only indices that the input field can carry are ever stored.
    localparam int DEPTH = (SENSORS < IDX_RANGE) ? SENSORS : IDX_RANGE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    limits_t   limits;
    flag_upd_t upd;

    logic advance;
    logic accept;
    logic in_range;

    // stage 1: waiting for the flag-table read
    logic              s1_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_in_range_reg;
    flag_upd_t         s1_upd_reg;

    // last flag-table write, for forwarding
    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [MASK_W-1:0] fwd_data_reg;

    logic [DEPTH-1:0]  vld_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [MASK_W-1:0] opened_reg;
    logic [MASK_W-1:0] cleared_reg;
    logic [MASK_W-1:0] active_reg;

    logic [AW-1:0]     s1_addr;
    logic [MASK_W-1:0] ram_rdata;
    logic [MASK_W-1:0] old_flags;
    logic [MASK_W-1:0] new_flags;
    logic              wr_en;

    sae_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    sae_eval u_eval (
        .sensor_kind     (sensor_kind),
        .reading_found   (reading_found),
        .reading_numeric (reading_numeric),
        .reading_value   (reading_value),
        .reading_age     (reading_age),
        .limits          (limits),
        .upd             (upd)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;
    assign in_range = {{(IDX_EXT_W-IDX_W){1'b0}}, sensor_index} < IDX_EXT_W'(SENSORS);

    assign s1_addr = s1_idx_reg[AW-1:0];
    assign wr_en   = advance && s1_valid_reg && s1_in_range_reg;

    always_comb
    begin
        priority if (!s1_in_range_reg)
        begin
            old_flags = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            old_flags = fwd_data_reg;
        end
        else if (vld_reg[s1_addr])
        begin
            old_flags = ram_rdata;
        end
        else
        begin
            old_flags = '0;
        end
        new_flags = s1_in_range_reg ?
                    ((old_flags & ~s1_upd_reg.eval) | (s1_upd_reg.cond & s1_upd_reg.eval)) :
                    '0;
    end

    sae_ram #(
        .WIDTH (MASK_W),
        .DEPTH (DEPTH)
    ) u_flags (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr),
        .wdata (new_flags),
        .re    (accept && in_range),
        .raddr (sensor_index[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= wr_en;
            out_valid_reg <= s1_valid_reg;
            if (wr_en)
            begin
                vld_reg[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_idx_reg      <= sensor_index;
            s1_in_range_reg <= in_range;
            s1_upd_reg      <= upd;
            fwd_addr_reg    <= s1_addr;
            fwd_data_reg    <= new_flags;
            out_idx_reg     <= s1_idx_reg;
            opened_reg      <= new_flags & ~old_flags;
            cleared_reg     <= old_flags & ~new_flags;
            active_reg      <= new_flags;
        end
    end

    assign out_valid    = out_valid_reg;
    assign alarm_sensor = out_idx_reg;
    assign opened_mask  = opened_reg;
    assign cleared_mask = cleared_reg;
    assign active_mask  = active_reg;

endmodule

/* rtl/core/sae_checker.sv */
// Port-level checker for the sensor alarm edge monitor, with its bind.
module sae_checker
    import sae_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [IDX_W-1:0]  alarm_sensor,
    input logic [MASK_W-1:0] opened_mask,
    input logic [MASK_W-1:0] cleared_mask,
    input logic [MASK_W-1:0] active_mask
);

    // An alarm cannot open and clear in the same step
    a_open_clear_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((opened_mask & cleared_mask) == '0))
        else $error("alarm both opened and cleared");

    // Every newly opened alarm is active afterwards
    a_opened_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((opened_mask & ~active_mask) == '0))
        else $error("opened alarm not active");

    // A cleared alarm is no longer active
    a_cleared_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((cleared_mask & active_mask) == '0))
        else $error("cleared alarm still active");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(alarm_sensor) &&
                                      $stable(opened_mask) && $stable(cleared_mask) &&
                                      $stable(active_mask)))
        else $error("stalled result changed");

endmodule

bind sensor_alarm_edge_monitor sae_checker u_sae_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .alarm_sensor (alarm_sensor),
    .opened_mask  (opened_mask),
    .cleared_mask (cleared_mask),
    .active_mask  (active_mask)
);
